[design/bps_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the Blinn-Phong point-light shader.
// -----------------------------------------------------------------------------
package bps_pkg;

    // direction component before normalization, and unit component (Q2.30)
    typedef logic signed [33:0] comp_t;
    typedef logic signed [31:0] unit_t;

    // normalizer stage counts
    localparam int SQ_STEPS   = 31;
    localparam int DV_STEPS   = 31;
    localparam int MSB_TARGET = 29;
    localparam int NORM_LAT   = 5 + SQ_STEPS + DV_STEPS + 1;

    // shader pipeline
    localparam int PW_STEPS   = 8;
    localparam int TOTAL_LAT  = 2 * NORM_LAT + 18;
    localparam int SIDE_LEN   = 2 * NORM_LAT + 15;
    localparam int SIDE_NRM   = 2 * NORM_LAT + 1;
    localparam int SIDE_LAMP  = 2 * NORM_LAT + 14;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [2:0] {
        REG_DIFFUSE_GAIN  = 3'd0,
        REG_SPECULAR_GAIN = 3'd1,
        REG_SHININESS     = 3'd2,
        REG_EYE_X         = 3'd3,
        REG_EYE_Y         = 3'd4,
        REG_EYE_Z         = 3'd5,
        REG_SURFACE       = 3'd6
    } reg_index_t;

    // values that ride along with a transaction
    typedef struct packed {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
    } side_t;

endpackage

[design/bps_normalize.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bps_normalize
// Pipelined 3-vector normalizer: block scaling, sum of squares, bit-serial
// square root and restoring division, one stage per result bit.
// -----------------------------------------------------------------------------
module bps_normalize (
    input  logic           aclk,
    input  logic           adv,
    input  bps_pkg::comp_t vec_in   [3],
    output bps_pkg::unit_t unit_out [3]
);
    import bps_pkg::*;

    logic [2:0]  n1_neg_reg,  n1_neg_next;
    logic [33:0] n1_mag_reg   [3];
    logic [33:0] n1_mag_next  [3];
    logic [33:0] n1_max_reg,  n1_max_next;

    logic [2:0]  n2_neg_reg;
    logic [33:0] n2_mag_reg   [3];
    logic [5:0]  n2_msb_reg,  n2_msb_next;
    logic        n2_zero_reg;

    logic [2:0]  n3_neg_reg;
    logic [29:0] n3_mag_reg   [3];
    logic [29:0] n3_mag_next  [3];
    logic        n3_zero_reg;

    logic [2:0]  n4_neg_reg;
    logic [29:0] n4_mag_reg   [3];
    logic [59:0] n4_sq_reg    [3];
    logic        n4_zero_reg;

    logic [2:0]  n5_neg_reg;
    logic [29:0] n5_mag_reg   [3];
    logic [63:0] n5_sum_reg;
    logic        n5_zero_reg;

    logic [63:0] sq_rem_reg   [SQ_STEPS];
    logic [63:0] sq_rem_next  [SQ_STEPS];
    logic [30:0] sq_root_reg  [SQ_STEPS];
    logic [30:0] sq_root_next [SQ_STEPS];
    logic [29:0] sq_mag_reg   [SQ_STEPS][3];
    logic [2:0]  sq_neg_reg   [SQ_STEPS];
    logic        sq_zero_reg  [SQ_STEPS];

    logic [60:0] dv_rem_reg   [DV_STEPS][3];
    logic [60:0] dv_rem_next  [DV_STEPS][3];
    logic [30:0] dv_quo_reg   [DV_STEPS][3];
    logic [30:0] dv_quo_next  [DV_STEPS][3];
    logic [30:0] dv_root_reg  [DV_STEPS];
    logic [2:0]  dv_neg_reg   [DV_STEPS];
    logic        dv_zero_reg  [DV_STEPS];

    unit_t       out_reg      [3];

    // magnitudes and largest magnitude
    always_comb begin
        n1_max_next = '0;
        for (int k = 0; k < 3; k++) begin
            n1_neg_next[k] = vec_in[k][33];
            n1_mag_next[k] = vec_in[k][33] ? 34'(-vec_in[k]) : 34'(vec_in[k]);
            if (n1_mag_next[k] > n1_max_next) begin
                n1_max_next = n1_mag_next[k];
            end
        end
    end

    // leading one of the largest magnitude
    always_comb begin
        n2_msb_next = '0;
        for (int b = 0; b < 34; b++) begin
            if (n1_max_reg[b]) begin
                n2_msb_next = 6'(b);
            end
        end
    end

    // common shift puts the largest magnitude in [2^29, 2^30)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (n2_msb_reg >= 6'(MSB_TARGET)) begin
                n3_mag_next[k] = 30'(n2_mag_reg[k] >> (n2_msb_reg - 6'(MSB_TARGET)));
            end else begin
                n3_mag_next[k] = 30'(n2_mag_reg[k] << (6'(MSB_TARGET) - n2_msb_reg));
            end
        end
    end

    // square root, one result bit per stage
    always_comb begin
        logic [63:0] rem_in;
        logic [30:0] root_in;
        logic [63:0] trial;
        for (int j = 0; j < SQ_STEPS; j++) begin
            rem_in  = (j == 0) ? n5_sum_reg : sq_rem_reg[(j == 0) ? 0 : j - 1];
            root_in = (j == 0) ? '0 : sq_root_reg[(j == 0) ? 0 : j - 1];
            trial   = ({33'b0, root_in} << (SQ_STEPS - j))
                      + (64'd1 << (2 * (SQ_STEPS - 1 - j)));
            if (rem_in >= trial) begin
                sq_rem_next[j]  = rem_in - trial;
                sq_root_next[j] = root_in | (31'd1 << (SQ_STEPS - 1 - j));
            end else begin
                sq_rem_next[j]  = rem_in;
                sq_root_next[j] = root_in;
            end
        end
    end

    // restoring division of (mag << 30) by the root, one quotient bit per stage
    always_comb begin
        logic [60:0] rem_in;
        logic [30:0] quo_in;
        logic [30:0] root_in;
        logic [60:0] dsor;
        for (int j = 0; j < DV_STEPS; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (j == 0) begin
                    rem_in  = {1'b0, sq_mag_reg[SQ_STEPS - 1][k], 30'b0};
                    quo_in  = '0;
                    root_in = sq_root_reg[SQ_STEPS - 1];
                end else begin
                    rem_in  = dv_rem_reg[(j == 0) ? 0 : j - 1][k];
                    quo_in  = dv_quo_reg[(j == 0) ? 0 : j - 1][k];
                    root_in = dv_root_reg[(j == 0) ? 0 : j - 1];
                end
                dsor = {30'b0, root_in} << (DV_STEPS - 1 - j);
                if (rem_in >= dsor) begin
                    dv_rem_next[j][k] = rem_in - dsor;
                    dv_quo_next[j][k] = quo_in | (31'd1 << (DV_STEPS - 1 - j));
                end else begin
                    dv_rem_next[j][k] = rem_in;
                    dv_quo_next[j][k] = quo_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_neg_reg  <= n1_neg_next;
            n1_mag_reg  <= n1_mag_next;
            n1_max_reg  <= n1_max_next;

            n2_neg_reg  <= n1_neg_reg;
            n2_mag_reg  <= n1_mag_reg;
            n2_msb_reg  <= n2_msb_next;
            n2_zero_reg <= (n1_max_reg == '0);

            n3_neg_reg  <= n2_neg_reg;
            n3_mag_reg  <= n3_mag_next;
            n3_zero_reg <= n2_zero_reg;

            n4_neg_reg  <= n3_neg_reg;
            n4_mag_reg  <= n3_mag_reg;
            n4_zero_reg <= n3_zero_reg;
            for (int k = 0; k < 3; k++) begin
                n4_sq_reg[k] <= 60'(n3_mag_reg[k]) * 60'(n3_mag_reg[k]);
            end

            n5_neg_reg  <= n4_neg_reg;
            n5_mag_reg  <= n4_mag_reg;
            n5_zero_reg <= n4_zero_reg;
            n5_sum_reg  <= 64'(n4_sq_reg[0]) + 64'(n4_sq_reg[1]) + 64'(n4_sq_reg[2]);

            for (int j = 0; j < SQ_STEPS; j++) begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                if (j == 0) begin
                    sq_mag_reg[j]  <= n5_mag_reg;
                    sq_neg_reg[j]  <= n5_neg_reg;
                    sq_zero_reg[j] <= n5_zero_reg;
                end else begin
                    sq_mag_reg[j]  <= sq_mag_reg[j - 1];
                    sq_neg_reg[j]  <= sq_neg_reg[j - 1];
                    sq_zero_reg[j] <= sq_zero_reg[j - 1];
                end
            end

            for (int j = 0; j < DV_STEPS; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_quo_reg[j] <= dv_quo_next[j];
                if (j == 0) begin
                    dv_root_reg[j] <= sq_root_reg[SQ_STEPS - 1];
                    dv_neg_reg[j]  <= sq_neg_reg[SQ_STEPS - 1];
                    dv_zero_reg[j] <= sq_zero_reg[SQ_STEPS - 1];
                end else begin
                    dv_root_reg[j] <= dv_root_reg[j - 1];
                    dv_neg_reg[j]  <= dv_neg_reg[j - 1];
                    dv_zero_reg[j] <= dv_zero_reg[j - 1];
                end
            end

            // restore signs; an all-zero vector gives a zero unit vector
            for (int k = 0; k < 3; k++) begin
                if (dv_zero_reg[DV_STEPS - 1]) begin
                    out_reg[k] <= '0;
                end else if (dv_neg_reg[DV_STEPS - 1][k]) begin
                    out_reg[k] <= -$signed({1'b0, dv_quo_reg[DV_STEPS - 1][k]});
                end else begin
                    out_reg[k] <= $signed({1'b0, dv_quo_reg[DV_STEPS - 1][k]});
                end
            end
        end
    end

    assign unit_out = out_reg;

endmodule

[design/blinn_phong_point_light_shader.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// blinn_phong_point_light_shader
// Fixed-point Blinn-Phong shading of one surface point lit by one point light.
// -----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted per cycle while the output is
// not stalled. Two normalizers lie in series on each transaction's path; each
// holds a 31-stage square root and a 31-stage divider, one result bit per
// stage. The whole pipeline holds while a result waits on m_ready.
// Configuration is written through the cfg port; the user must do so only
// while no transaction is in flight, as the block itself does not enforce it.
// cfg_ready is always high and indexes above six are dropped.
module blinn_phong_point_light_shader (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic signed [17:0] s_normal_x,
    input  logic signed [17:0] s_normal_y,
    input  logic signed [17:0] s_normal_z,
    input  logic signed [31:0] s_lamp_x,
    input  logic signed [31:0] s_lamp_y,
    input  logic signed [31:0] s_lamp_z,
    input  logic [15:0]        s_lamp_red,
    input  logic [15:0]        s_lamp_green,
    input  logic [15:0]        s_lamp_blue,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_shade_red,
    output logic [15:0]        m_shade_green,
    output logic [15:0]        m_shade_blue
);
    import bps_pkg::*;

    logic [15:0]        diffuse_gain_reg;
    logic [15:0]        specular_gain_reg;
    logic [7:0]         shininess_reg;
    logic signed [31:0] eye_reg [3];
    logic [47:0]        surface_reg;

    logic               adv;
    logic [TOTAL_LAT-1:0] valid_reg;

    comp_t              lvec_reg [3];
    comp_t              evec_reg [3];
    comp_t              hvec_reg [3];
    unit_t              lunit    [3];
    unit_t              eunit    [3];
    unit_t              hunit    [3];
    unit_t              ld_reg   [NORM_LAT + 1][3];
    side_t              side_reg [SIDE_LEN];
    side_t              side_nrm;

    logic signed [49:0] dpl_reg [3];
    logic signed [49:0] dph_reg [3];
    logic signed [51:0] dsl_reg, dsh_reg;
    logic [30:0]        dl_reg [PW_STEPS + 1];
    logic [30:0]        dh_reg;
    logic [30:0]        pw_acc_reg  [PW_STEPS];
    logic [30:0]        pw_base_reg [PW_STEPS];
    logic [30:0]        pw_acc_next  [PW_STEPS];
    logic [30:0]        pw_base_next [PW_STEPS];

    logic [46:0]        pd_reg, ps_reg;
    logic [33:0]        t_reg;
    logic [35:0]        u_reg [3];
    logic [21:0]        v_reg [3];
    logic [15:0]        shade_reg [3];
    logic [15:0]        lamp_col [3];

    function automatic logic [30:0] clamp_dot(input logic signed [51:0] sum);
        logic [35:0] d;
        d = sum[51:16];
        if (sum <= 0) begin
            return '0;
        end else if (d > 36'(ONE_Q30)) begin
            return ONE_Q30;
        end else begin
            return d[30:0];
        end
    endfunction

    // hold the whole pipeline while a finished result waits
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diffuse_gain_reg  <= 16'd8192;
            specular_gain_reg <= 16'd16384;
            shininess_reg     <= 8'd32;
            eye_reg[0]        <= 32'sd0;
            eye_reg[1]        <= 32'sd0;
            eye_reg[2]        <= 32'sd340787;
            surface_reg       <= 48'h4000_4000_4000;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DIFFUSE_GAIN:  diffuse_gain_reg  <= cfg_data[15:0];
                REG_SPECULAR_GAIN: specular_gain_reg <= cfg_data[15:0];
                REG_SHININESS:     shininess_reg     <= cfg_data[7:0];
                REG_EYE_X:         eye_reg[0]        <= $signed(cfg_data[31:0]);
                REG_EYE_Y:         eye_reg[1]        <= $signed(cfg_data[31:0]);
                REG_EYE_Z:         eye_reg[2]        <= $signed(cfg_data[31:0]);
                REG_SURFACE:       surface_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    bps_normalize u_norm_l (.aclk(aclk), .adv(adv), .vec_in(lvec_reg), .unit_out(lunit));
    bps_normalize u_norm_e (.aclk(aclk), .adv(adv), .vec_in(evec_reg), .unit_out(eunit));
    bps_normalize u_norm_h (.aclk(aclk), .adv(adv), .vec_in(hvec_reg), .unit_out(hunit));

    // square and multiply, one exponent bit per stage
    always_comb begin
        logic [30:0] acc_in;
        logic [30:0] base_in;
        logic [61:0] pa;
        logic [61:0] pb;
        for (int k = 0; k < PW_STEPS; k++) begin
            acc_in  = (k == 0) ? ONE_Q30 : pw_acc_reg[(k == 0) ? 0 : k - 1];
            base_in = (k == 0) ? dh_reg : pw_base_reg[(k == 0) ? 0 : k - 1];
            pa = 62'(acc_in) * 62'(base_in);
            pb = 62'(base_in) * 62'(base_in);
            pw_acc_next[k]  = shininess_reg[k] ? pa[60:30] : acc_in;
            pw_base_next[k] = pb[60:30];
        end
    end

    assign side_nrm    = side_reg[SIDE_NRM];
    assign lamp_col[0] = side_reg[SIDE_LAMP].red;
    assign lamp_col[1] = side_reg[SIDE_LAMP].green;
    assign lamp_col[2] = side_reg[SIDE_LAMP].blue;

    always_ff @(posedge aclk) begin
        if (adv) begin
            // direction vectors from the surface point
            lvec_reg[0] <= 34'(s_lamp_x) - 34'(s_point_x);
            lvec_reg[1] <= 34'(s_lamp_y) - 34'(s_point_y);
            lvec_reg[2] <= 34'(s_lamp_z) - 34'(s_point_z);
            evec_reg[0] <= 34'(eye_reg[0]) - 34'(s_point_x);
            evec_reg[1] <= 34'(eye_reg[1]) - 34'(s_point_y);
            evec_reg[2] <= 34'(eye_reg[2]) - 34'(s_point_z);
            side_reg[0] <= '{nx: s_normal_x, ny: s_normal_y, nz: s_normal_z,
                             red: s_lamp_red, green: s_lamp_green, blue: s_lamp_blue};
            for (int i = 1; i < SIDE_LEN; i++) begin
                side_reg[i] <= side_reg[i - 1];
            end

            // half vector
            for (int k = 0; k < 3; k++) begin
                hvec_reg[k]  <= 34'(lunit[k]) + 34'(eunit[k]);
                ld_reg[0][k] <= lunit[k];
            end
            for (int i = 1; i <= NORM_LAT; i++) begin
                ld_reg[i] <= ld_reg[i - 1];
            end

            // dot products with the normal
            dpl_reg[0] <= 50'(side_nrm.nx) * 50'(ld_reg[NORM_LAT][0]);
            dpl_reg[1] <= 50'(side_nrm.ny) * 50'(ld_reg[NORM_LAT][1]);
            dpl_reg[2] <= 50'(side_nrm.nz) * 50'(ld_reg[NORM_LAT][2]);
            dph_reg[0] <= 50'(side_nrm.nx) * 50'(hunit[0]);
            dph_reg[1] <= 50'(side_nrm.ny) * 50'(hunit[1]);
            dph_reg[2] <= 50'(side_nrm.nz) * 50'(hunit[2]);
            dsl_reg <= 52'(dpl_reg[0]) + 52'(dpl_reg[1]) + 52'(dpl_reg[2]);
            dsh_reg <= 52'(dph_reg[0]) + 52'(dph_reg[1]) + 52'(dph_reg[2]);
            dl_reg[0] <= clamp_dot(dsl_reg);
            dh_reg    <= clamp_dot(dsh_reg);
            for (int i = 1; i <= PW_STEPS; i++) begin
                dl_reg[i] <= dl_reg[i - 1];
            end

            pw_acc_reg  <= pw_acc_next;
            pw_base_reg <= pw_base_next;

            // weight, light colour, surface colour, saturate
            pd_reg <= 47'(diffuse_gain_reg) * 47'(dl_reg[PW_STEPS]);
            ps_reg <= 47'(specular_gain_reg) * 47'(pw_acc_reg[PW_STEPS - 1]);
            t_reg  <= 34'((48'(pd_reg) + 48'(ps_reg)) >> 14);
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= 36'((50'(t_reg) * 50'(lamp_col[k])) >> 14);
                v_reg[k] <= 22'((52'(u_reg[k]) * 52'(surface_reg[47 - 16 * k -: 16])) >> 30);
                shade_reg[k] <= (v_reg[k] > 22'd65535) ? 16'hFFFF : v_reg[k][15:0];
            end
        end
    end

    assign m_shade_red   = shade_reg[0];
    assign m_shade_green = shade_reg[1];
    assign m_shade_blue  = shade_reg[2];

    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted transaction missing from first stage");

    a_ready_backpressure : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(valid_reg) && $stable(m_shade_red))
        else $error("pipeline moved during stall");

endmodule
